// ----- src/ttsg_pkg.sv -----
// ttsg_pkg: shared types and constants of the tap / stroke gesture detector
// gesture codes, configuration register indexes and the configuration struct
// no dependencies
package ttsg_pkg;

  // gesture codes carried by each result
  typedef enum logic [1:0] {
    GESTURE_NONE       = 2'd0,
    GESTURE_DOUBLE_TAP = 2'd1,
    GESTURE_STROKE     = 2'd2
  } gesture_t;

  // configuration port geometry
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int TIME_BITS     = 32;
  localparam int CFG_TIME_BITS = 16;
  localparam int SPAN_BITS     = 12;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_TIME  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_TIME = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STROKE_SPAN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_MAX      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DTAP_WINDOW  = 3'd4;

  // register reset values
  localparam logic [CFG_TIME_BITS-1:0] SETTLE_TIME_RST  = 16'd60;
  localparam logic [CFG_TIME_BITS-1:0] RELEASE_TIME_RST = 16'd80;
  localparam logic [SPAN_BITS-1:0]     STROKE_SPAN_RST  = 12'd600;
  localparam logic [CFG_TIME_BITS-1:0] TAP_MAX_RST      = 16'd250;
  localparam logic [CFG_TIME_BITS-1:0] DTAP_WINDOW_RST  = 16'd400;

  // configuration values as seen by the detector core
  typedef struct packed {
    logic [CFG_TIME_BITS-1:0] settle_time_ms;
    logic [CFG_TIME_BITS-1:0] release_time_ms;
    logic [SPAN_BITS-1:0]     stroke_min_span;
    logic [CFG_TIME_BITS-1:0] tap_limit_ms;
    logic [CFG_TIME_BITS-1:0] double_tap_window_ms;
  } ttsg_cfg_t;

endpackage

// ----- src/ttsg_in_if.sv -----
// ttsg_in_if: touch sample channel, valid / ready with sample payload
// no dependencies
interface ttsg_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  touched;
  logic [COORD_BITS-1:0] raw_x;
  logic [31:0]           now_ms;

  modport source (output valid, output touched, output raw_x, output now_ms, input ready);
  modport sink   (input valid, input touched, input raw_x, input now_ms, output ready);
endinterface

// ----- src/ttsg_out_if.sv -----
// ttsg_out_if: gesture result channel, valid / ready with gesture code
// no dependencies
interface ttsg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

// ----- src/touch_tap_stroke_gesture.sv -----
// touch_tap_stroke_gesture: double tap and stroke detector for touch samples
// an accepted sample request is held in the sample register, then its gesture in the result register;
// either one can wait there while the result output is stalled
// throughput: one sample per cycle while results are taken, set by the state update between registers
// reset (rst_n low, synchronous) restores register defaults and clears contact state
// depends on ttsg_pkg, ttsg_in_if, ttsg_out_if, ttsg_cfg, ttsg_core
module touch_tap_stroke_gesture
  import ttsg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ttsg_in_if.sink                  in_ch,
  ttsg_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  ttsg_cfg_t cfg;
  gesture_t  gesture;

  logic                  in_v_r, in_v_nxt;
  logic                  touched_r;
  logic [COORD_BITS-1:0] raw_x_r;
  logic [TIME_BITS-1:0]  now_r;
  logic                  out_v_r, out_v_nxt;
  gesture_t              gesture_r;
  logic                  in_take;
  logic                  advance;

  ttsg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttsg_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .touched (touched_r),
    .raw_x   (raw_x_r),
    .now_ms  (now_r),
    .cfg     (cfg),
    .gesture (gesture)
  );

  // pipeline handshake: sample moves on when the result slot is free or draining
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign in_v_nxt     = in_take || (in_v_r && !advance);
  assign out_v_nxt    = advance || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (in_take) begin
      touched_r <= in_ch.touched;
      raw_x_r   <= in_ch.raw_x;
      now_r     <= in_ch.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_r <= gesture;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.gesture = gesture_r;

endmodule

// ----- src/ttsg_cfg.sv -----
// ttsg_cfg: configuration registers of the gesture detector
// depends on ttsg_pkg
module ttsg_cfg
  import ttsg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output ttsg_cfg_t                cfg
);

  ttsg_cfg_t cfg_r;
  ttsg_cfg_t cfg_nxt;

  // register decode, unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETTLE_TIME:  cfg_nxt.settle_time_ms       = cfg_wdata;
        CFG_RELEASE_TIME: cfg_nxt.release_time_ms      = cfg_wdata;
        CFG_STROKE_SPAN:  cfg_nxt.stroke_min_span      = cfg_wdata[SPAN_BITS-1:0];
        CFG_TAP_MAX:      cfg_nxt.tap_limit_ms         = cfg_wdata;
        CFG_DTAP_WINDOW:  cfg_nxt.double_tap_window_ms = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_time_ms       <= SETTLE_TIME_RST;
      cfg_r.release_time_ms      <= RELEASE_TIME_RST;
      cfg_r.stroke_min_span      <= STROKE_SPAN_RST;
      cfg_r.tap_limit_ms         <= TAP_MAX_RST;
      cfg_r.double_tap_window_ms <= DTAP_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ttsg_core.sv -----
// ttsg_core: contact tracking state and gesture classification
// one sample is processed in each cycle in which step_en is high
// depends on ttsg_pkg
module ttsg_core
  import ttsg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  touched,
  input  logic [COORD_BITS-1:0] raw_x,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  ttsg_cfg_t             cfg,
  output gesture_t              gesture
);

  // compare width covering both coordinate span and threshold
  localparam int CMP_BITS = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS;

  logic                  in_contact_r, in_contact_nxt;
  logic                  settled_r, settled_nxt;
  logic [TIME_BITS-1:0]  start_r, start_nxt;
  logic [TIME_BITS-1:0]  last_seen_r, last_seen_nxt;
  logic [TIME_BITS-1:0]  pending_r, pending_nxt;
  logic [COORD_BITS-1:0] min_x_r, min_x_nxt;
  logic [COORD_BITS-1:0] max_x_r, max_x_nxt;

  logic [TIME_BITS-1:0]  since_start;
  logic [TIME_BITS-1:0]  since_seen;
  logic [TIME_BITS-1:0]  duration;
  logic [TIME_BITS-1:0]  since_tap;
  logic [COORD_BITS-1:0] span;
  logic                  is_settled_time;
  logic                  is_release;
  logic                  is_stroke;
  logic                  is_tap;
  logic                  is_double;

  // wrapping time differences, all in parallel
  assign since_start = now_ms - start_r;
  assign since_seen  = now_ms - last_seen_r;
  assign duration    = last_seen_r - start_r;
  assign since_tap   = now_ms - pending_r;
  assign span        = (max_x_r >= min_x_r) ? (max_x_r - min_x_r) : '0;

  assign is_settled_time = since_start >= TIME_BITS'(cfg.settle_time_ms);
  assign is_release      = !touched && in_contact_r &&
                           (since_seen >= TIME_BITS'(cfg.release_time_ms));
  assign is_stroke       = CMP_BITS'(span) >= CMP_BITS'(cfg.stroke_min_span);
  assign is_tap          = duration <= TIME_BITS'(cfg.tap_limit_ms);
  assign is_double       = (pending_r != '0) &&
                           (since_tap <= TIME_BITS'(cfg.double_tap_window_ms));

  // next state and gesture for the current sample
  always_comb begin
    in_contact_nxt = in_contact_r;
    settled_nxt    = settled_r;
    start_nxt      = start_r;
    last_seen_nxt  = last_seen_r;
    pending_nxt    = pending_r;
    min_x_nxt      = min_x_r;
    max_x_nxt      = max_x_r;
    gesture        = GESTURE_NONE;
    if (touched) begin
      last_seen_nxt = now_ms;
      if (!in_contact_r) begin
        // contact start
        in_contact_nxt = 1'b1;
        start_nxt      = now_ms;
        min_x_nxt      = raw_x;
        max_x_nxt      = raw_x;
        settled_nxt    = 1'b0;
      end else if (is_settled_time) begin
        if (!settled_r) begin
          // first tracked sample restarts the range
          min_x_nxt   = raw_x;
          max_x_nxt   = raw_x;
          settled_nxt = 1'b1;
        end else begin
          if (raw_x < min_x_r) min_x_nxt = raw_x;
          if (raw_x > max_x_r) max_x_nxt = raw_x;
        end
      end
    end else if (is_release) begin
      in_contact_nxt = 1'b0;
      if (is_stroke) begin
        gesture     = GESTURE_STROKE;
        pending_nxt = '0;
      end else if (is_tap) begin
        if (is_double) begin
          gesture     = GESTURE_DOUBLE_TAP;
          pending_nxt = '0;
        end else begin
          pending_nxt = now_ms;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_contact_r <= 1'b0;
      settled_r    <= 1'b0;
      pending_r    <= '0;
    end else if (step_en) begin
      in_contact_r <= in_contact_nxt;
      settled_r    <= settled_nxt;
      pending_r    <= pending_nxt;
    end
  end

  // contact times and x range, read only while in contact
  always_ff @(posedge clk) begin
    if (step_en) begin
      start_r     <= start_nxt;
      last_seen_r <= last_seen_nxt;
      min_x_r     <= min_x_nxt;
      max_x_r     <= max_x_nxt;
    end
  end

endmodule

// ----- bench/tb_touch_tap_stroke_gesture.sv -----
// tb_touch_tap_stroke_gesture: self-checking bench for the tap / stroke gesture detector
// drives touch sample requests, predicts each gesture code and checks every result in order
// depends on ttsg_pkg, ttsg_in_if, ttsg_out_if and touch_tap_stroke_gesture
module tb_touch_tap_stroke_gesture;
  timeunit 1ns;
  timeprecision 1ps;

  import ttsg_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int X_MAX          = (1 << COORD_BITS) - 1;
  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct {
    logic                  touched;
    logic [COORD_BITS-1:0] raw_x;
    logic [31:0]           now_ms;
  } touch_sample_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  ttsg_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
  ttsg_out_if                           out_ch();

  touch_tap_stroke_gesture #(.COORD_BITS(COORD_BITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // stimulus and expectation stores
  touch_sample_t pending_samples[$];
  gesture_t      expected_gestures[$];
  touch_sample_t next_sample;
  gesture_t      want_gesture;
  int unsigned   n_queued = 0;
  int unsigned   n_results = 0;
  int unsigned   mismatch_count = 0;
  bit            calm = 1'b0;
  bit            feed_hold = 1'b0;
  logic [31:0]   clock_ms = '0;

  // predictor copy of the registers and the contact state
  ttsg_cfg_t             cur_cfg;
  logic                  touch_active = 1'b0;
  logic [31:0]           touch_start_ms = '0;
  logic [31:0]           touch_last_ms = '0;
  logic [31:0]           first_tap_ms = '0;
  logic [COORD_BITS-1:0] x_low = '0;
  logic [COORD_BITS-1:0] x_high = '0;
  logic                  x_tracking = 1'b0;

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at result %0d: %s", n_results, msg);
    mismatch_count++;
  endtask

  // gesture expected for one accepted sample, updates the contact state
  function automatic gesture_t predict_gesture(logic touched, logic [COORD_BITS-1:0] x,
                                               logic [31:0] ms);
    gesture_t              verdict;
    logic [31:0]           elapsed;
    logic [31:0]           held_ms;
    logic [COORD_BITS-1:0] spread;
    verdict = GESTURE_NONE;
    if (touched) begin
      touch_last_ms = ms;
      elapsed = ms - touch_start_ms;
      if (!touch_active) begin
        touch_active = 1'b1;
        touch_start_ms = ms;
        x_low = x;
        x_high = x;
        x_tracking = 1'b0;
      end else if (elapsed >= 32'(cur_cfg.settle_time_ms)) begin
        if (!x_tracking) begin
          x_low = x;
          x_high = x;
          x_tracking = 1'b1;
        end
        if (x < x_low) x_low = x;
        if (x > x_high) x_high = x;
      end
    end else if (touch_active) begin
      elapsed = ms - touch_last_ms;
      if (elapsed >= 32'(cur_cfg.release_time_ms)) begin
        held_ms = touch_last_ms - touch_start_ms;
        spread = (x_high >= x_low) ? x_high - x_low : '0;
        touch_active = 1'b0;
        if (spread >= cur_cfg.stroke_min_span) begin
          verdict = GESTURE_STROKE;
          first_tap_ms = '0;
        end else if (held_ms <= 32'(cur_cfg.tap_limit_ms)) begin
          elapsed = ms - first_tap_ms;
          if (first_tap_ms != 0 && elapsed <= 32'(cur_cfg.double_tap_window_ms)) begin
            verdict = GESTURE_DOUBLE_TAP;
            first_tap_ms = '0;
          end else begin
            first_tap_ms = ms;
          end
        end
      end
    end
    return verdict;
  endfunction

  // register write while the detector is idle, mirrored into the predictor
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SETTLE_TIME:  cur_cfg.settle_time_ms = data;
      CFG_RELEASE_TIME: cur_cfg.release_time_ms = data;
      CFG_STROKE_SPAN:  cur_cfg.stroke_min_span = data[SPAN_BITS-1:0];
      CFG_TAP_MAX:      cur_cfg.tap_limit_ms = data;
      CFG_DTAP_WINDOW:  cur_cfg.double_tap_window_ms = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] settle, logic [15:0] release_ms, logic [15:0] span,
                            logic [15:0] tap_max, logic [15:0] window);
    write_reg(CFG_SETTLE_TIME, settle);
    write_reg(CFG_RELEASE_TIME, release_ms);
    write_reg(CFG_STROKE_SPAN, span);
    write_reg(CFG_TAP_MAX, tap_max);
    write_reg(CFG_DTAP_WINDOW, window);
  endtask

  // wait until every sample is accepted and every gesture has come back
  task automatic drain();
    while (pending_samples.size() != 0 || in_ch.valid || expected_gestures.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_sample(logic touched, logic [COORD_BITS-1:0] x, logic [31:0] ms);
    touch_sample_t s;
    s.touched = touched;
    s.raw_x = x;
    s.now_ms = ms;
    pending_samples.push_back(s);
    n_queued++;
  endtask

  // one contact: pressed samples over dur with the last two at the span ends,
  // an optional bounce shorter than the release time, then the release sample
  task automatic add_contact(int unsigned dur, int unsigned span, int unsigned extra,
                             int unsigned max_touch, bit bounce);
    int unsigned           n, lo, hi, step, back, k;
    bit                    flip;
    logic [31:0]           start_ms, at_ms;
    logic [COORD_BITS-1:0] xv;
    if (span > X_MAX) span = X_MAX;
    n = (dur == 0) ? 1 : $urandom_range(3, max_touch);
    lo = $urandom_range(0, X_MAX - span);
    hi = lo + span;
    step = $urandom_range(0, 3);
    flip = 1'($urandom_range(0, 1));
    start_ms = clock_ms;
    at_ms = start_ms;
    for (k = 0; k < n; k++) begin
      if (k != 0) begin
        back = (n - 1 - k) * step;
        at_ms = start_ms + ((back > dur) ? 0 : dur - back);
      end
      if (k == n - 1) xv = COORD_BITS'(flip ? lo : hi);
      else if (k == n - 2) xv = COORD_BITS'(flip ? hi : lo);
      else xv = COORD_BITS'($urandom_range(lo, hi));
      add_sample(1'b1, xv, at_ms);
    end
    if (bounce && cur_cfg.release_time_ms > 1 && $urandom_range(0, 3) == 0)
      add_sample(1'b0, COORD_BITS'($urandom_range(0, X_MAX)),
                 at_ms + $urandom_range(0, cur_cfg.release_time_ms - 1));
    clock_ms = at_ms + cur_cfg.release_time_ms + extra;
    add_sample(1'b0, COORD_BITS'($urandom_range(0, X_MAX)), clock_ms);
  endtask

  function automatic int unsigned span_below();
    int unsigned s;
    s = 32'(cur_cfg.stroke_min_span);
    if (s == 0) return 0;
    return ($urandom_range(0, 1) != 0) ? s - 1 : $urandom_range(0, s - 1);
  endfunction

  // contact length around the tap limit
  function automatic int unsigned tap_duration();
    int unsigned t;
    t = 32'(cur_cfg.tap_limit_ms);
    case ($urandom_range(0, 3))
      0: return t;
      1: return t + 1;
      2: return $urandom_range(0, t);
      default: return $urandom_range(0, (t < 30) ? t : 30);
    endcase
  endfunction

  // one random gesture sequence, with some noise and idle samples mixed in
  task automatic add_random_gesture();
    int unsigned pick, d, sp, target, lead;
    logic [31:0] first_release;
    pick = $urandom_range(0, 99);
    clock_ms += $urandom_range(1, 50);
    if (pick < 12) begin
      add_sample(1'($urandom_range(0, 1)), COORD_BITS'($urandom_range(0, X_MAX)), $urandom);
    end else if (pick < 18) begin
      add_sample(1'b0, COORD_BITS'($urandom_range(0, X_MAX)), clock_ms);
    end else if (pick < 38) begin
      // stroke, long enough that the span ends fall after the settle time
      sp = 32'(cur_cfg.stroke_min_span);
      case ($urandom_range(0, 2))
        0: ;
        1: sp = X_MAX;
        default: if (sp < X_MAX) sp = sp + $urandom_range(1, X_MAX - sp);
      endcase
      d = cur_cfg.settle_time_ms + 20 + $urandom_range(0, 300);
      add_contact(d, sp, $urandom_range(0, 2), 6, 1'b1);
    end else if (pick < 48) begin
      // still contact held past the tap limit
      d = cur_cfg.tap_limit_ms + $urandom_range(1, 200);
      add_contact(d, span_below(), 0, 6, 1'b1);
    end else if (pick < 70) begin
      add_contact(tap_duration(), span_below(), $urandom_range(0, 2), 6, 1'b1);
    end else begin
      // tap pair with the release gap placed around the double tap window
      add_contact(tap_duration(), span_below(), 0, 6, 1'b1);
      first_release = clock_ms;
      case ($urandom_range(0, 3))
        0: target = 32'(cur_cfg.double_tap_window_ms);
        1: target = cur_cfg.double_tap_window_ms + 1;
        2: target = $urandom_range(0, cur_cfg.double_tap_window_ms);
        default: target = cur_cfg.double_tap_window_ms + $urandom_range(2, 500);
      endcase
      d = tap_duration();
      lead = d + cur_cfg.release_time_ms;
      clock_ms = first_release + ((target > lead) ? target - lead : 1);
      add_contact(d, span_below(), 0, 6, 1'b0);
    end
  endtask

  task automatic fill_random(int unsigned goal);
    while (n_queued < goal) add_random_gesture();
  endtask

  // request driver: launches queued samples, predicts on every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_gestures.push_back(predict_gesture(in_ch.touched, in_ch.raw_x, in_ch.now_ms));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && !feed_hold &&
            (calm || $urandom_range(0, 99) >= 15)) begin
          next_sample = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.touched <= next_sample.touched;
          in_ch.raw_x <= next_sample.raw_x;
          in_ch.now_ms <= next_sample.now_ms;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure and in-order comparison
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gestures.size() == 0) begin
          report_mismatch($sformatf("gesture %0d with nothing expected", out_ch.gesture));
        end else begin
          want_gesture = expected_gestures.pop_front();
          if (out_ch.gesture !== want_gesture)
            report_mismatch($sformatf("gesture %0d, expected %0d", out_ch.gesture,
                                      want_gesture));
        end
        n_results++;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // main sequence: reset, directed cases, then random phases under several settings
  initial begin
    cur_cfg.settle_time_ms = SETTLE_TIME_RST;
    cur_cfg.release_time_ms = RELEASE_TIME_RST;
    cur_cfg.stroke_min_span = STROKE_SPAN_RST;
    cur_cfg.tap_limit_ms = TAP_MAX_RST;
    cur_cfg.double_tap_window_ms = DTAP_WINDOW_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    add_sample(1'b0, '0, '0);
    // tap released exactly at time zero across the wrap: not pending afterwards
    clock_ms = 32'hFFFF_FF9C;
    add_contact(20, 0, 0, 3, 1'b0);
    clock_ms += 30;
    add_contact(30, 0, 0, 3, 1'b0);
    // tap of exactly the tap limit within the window gives a double tap
    clock_ms += 40;
    add_contact(250, 10, 0, 3, 1'b0);
    // full-width stroke, span exactly at threshold, span one below
    clock_ms += 20;
    add_contact(200, X_MAX, 0, 3, 1'b0);
    clock_ms += 20;
    add_contact(300, 600, 5, 3, 1'b0);
    clock_ms += 20;
    add_contact(100, 599, 0, 3, 1'b0);
    // long still contact leaves the pending tap alone
    clock_ms += 20;
    add_contact(251, 0, 0, 3, 1'b0);
    add_sample(1'b1, COORD_BITS'(X_MAX), 32'hFFFF_FFFF);
    add_sample(1'b0, '0, 32'hFFFF_FFFF);
    drain();

    // moderate settings with no idling on either side
    calm <= 1'b1;
    set_config(16'($urandom_range(0, 120)), 16'($urandom_range(1, 150)),
               16'($urandom_range(50, 1500)), 16'($urandom_range(30, 400)),
               16'($urandom_range(100, 900)));
    fill_random(230);
    drain();
    calm <= 1'b0;

    // all registers at zero: every release is a stroke
    set_config('0, '0, '0, '0, '0);
    clock_ms = $urandom;
    fill_random(430);
    drain();

    // all registers at their maximum, starting close to the time wrap
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFE_0000 + $urandom_range(0, 16'hFFFF);
    fill_random(630);
    drain();

    // full-range random settings; halfway the sender holds until all results are in
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    fill_random(830);
    while (pending_samples.size() > 100) @(posedge clk);
    feed_hold <= 1'b1;
    @(posedge clk);
    while (in_ch.valid || expected_gestures.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    feed_hold <= 1'b0;
    drain();

    // unused register indexes must change nothing, then back to the reset values
    write_reg(3'd5, 16'($urandom_range(0, 65535)));
    write_reg(3'd6, 16'($urandom_range(0, 65535)));
    write_reg(3'd7, 16'($urandom_range(0, 65535)));
    set_config(SETTLE_TIME_RST, RELEASE_TIME_RST, 16'(STROKE_SPAN_RST), TAP_MAX_RST,
               DTAP_WINDOW_RST);
    fill_random(1050);
    drain();

    repeat (4) @(posedge clk);
    if (expected_gestures.size() != 0)
      report_mismatch($sformatf("%0d gestures never arrived", expected_gestures.size()));
    if (mismatch_count == 0) begin
      $display("PASS touch_tap_stroke_gesture");
    end else begin
      $display("FAIL touch_tap_stroke_gesture");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL touch_tap_stroke_gesture");
    $finish;
  end

endmodule
